// File: design/sce_pkg.sv
// Shared types and constants for the seam cumulative energy block.
// No dependencies; imported by the output queue and the top level.
package sce_pkg;

	localparam int ENERGY_W = 8;
	localparam int COST_W = 16;
	localparam int LEN_W = 11;
	localparam int LEN_RESET = 1024;
	localparam logic [COST_W-1:0] COST_MAX = '1;

	// Output queue geometry; four entries cover the compute stage plus a full
	// round trip of the downstream ready.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;
	localparam int FIFO_CW = 3;

	typedef struct packed {
		logic line_end;
		logic [COST_W-1:0] path_cost;
	} sce_result_t;

endpackage

// File: design/seam_cumulative_energy.sv
// Top level of the seam cumulative energy block: stream ports, line store,
// compute stage and output queue. Depends on sce_pkg, sce_ram and sce_out_fifo.
//
// Usage: pixel energies enter on the s_ channel one line at a time, starting at
// the far edge of the image. s_tuser marks the first item of an image. Each
// item yields exactly one result on the m_ channel: the cumulative seam cost
// at that pixel (saturating at 65535), with m_tlast high on the last item of
// each line. The line length is written through the cfg_ channel while the
// block is idle; zero is taken as one and values above MAX_LINE as MAX_LINE.
//
// Timing: an item accepted at one edge is computed in the next cycle and is
// visible on m_tdata in the cycle after that when the output is not stalled.
// One item per cycle is sustained while the receiver keeps up; the previous
// line is held in a line store with two read ports, read as the item is
// accepted and written in the next cycle, with one-entry forwarding for the
// short lines where a read meets the write of the item just before it.
//
// Reset clears position and the queue, sets first-line mode and resets the line
// length; the line store is not cleared. Stalled results fill a four-entry
// queue; s_tready drops once the queue and compute stage together hold four.
module seam_cumulative_energy #(
	parameter int MAX_LINE = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input items.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] pixel_energy
	input  logic                          s_tuser,  // [0] image_start
	// Result items.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,  // [15:0] path_cost
	output logic                          m_tlast,  // line_end
	// Line length register.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sce_pkg::LEN_W-1:0]     cfg_data
);
	import sce_pkg::*;

	localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
	localparam int LW = ($clog2(MAX_LINE + 1) > LEN_W) ? $clog2(MAX_LINE + 1) : LEN_W;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_LINE);
	localparam logic [LW-1:0] RESET_LEN = LW'((MAX_LINE < LEN_RESET) ? MAX_LINE : LEN_RESET);

	// Control state.
	logic [LW-1:0]      eff_len_q;
	logic [AW-1:0]      position_q;
	logic               first_q;
	logic [COST_W-1:0]  held_q;
	logic               s1_valid;
	logic               fwd_valid_q;

	// Compute stage payload.
	logic [AW-1:0]       p_s1;
	logic [AW-1:0]       rb_addr_s1;
	logic [ENERGY_W-1:0] energy_s1;
	logic                first_s1;
	logic                last_s1;
	logic                has_left_s1;
	logic                has_right_s1;
	logic [AW-1:0]       fwd_addr_q;
	logic [COST_W-1:0]   fwd_data_q;

	// Accept side.
	logic                accept;
	logic [AW-1:0]       pos_base;
	logic [AW-1:0]       p_s0;
	logic [LW-1:0]       p_next_w;
	logic                last_s0;
	logic                first_s0;
	logic [AW-1:0]       rb_addr_s0;
	logic [LW-1:0]       cfg_len;

	// Compute side.
	logic [COST_W-1:0]   rd_center;
	logic [COST_W-1:0]   rd_right;
	logic [COST_W-1:0]   center;
	logic [COST_W-1:0]   right;
	logic [COST_W-1:0]   best;
	logic [COST_W:0]     sum;
	logic [COST_W-1:0]   cost;

	sce_result_t         push_data;
	sce_result_t         head;
	logic [FIFO_CW-1:0]  fifo_count;

	assign cfg_ready = 1'b1;

	// The queue must hold every item in flight; an item accepted now is
	// pushed in the next cycle, so count the compute stage as occupied.
	assign s_tready = ((fifo_count + FIFO_CW'(s1_valid)) < FIFO_CW'(FIFO_DEPTH));
	assign accept = s_tvalid && s_tready;

	always_comb begin
		pos_base = s_tuser ? '0 : position_q;
		// A line length shrunk under the current position restarts the line.
		p_s0 = (LW'(pos_base) >= eff_len_q) ? '0 : pos_base;
		p_next_w = LW'(p_s0) + LW'(1);
		last_s0 = (p_next_w >= eff_len_q);
		first_s0 = s_tuser || first_q;
		rb_addr_s0 = last_s0 ? '0 : AW'(p_next_w);
	end

	always_comb begin
		cfg_len = LW'(cfg_data);
		if (cfg_len == '0) begin
			cfg_len = LW'(1);
		end else if (cfg_len > MAX_LEN) begin
			cfg_len = MAX_LEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_len_q <= RESET_LEN;
			position_q <= '0;
			first_q <= 1'b1;
			held_q <= '0;
			s1_valid <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				eff_len_q <= cfg_len;
			end
			if (accept) begin
				position_q <= last_s0 ? '0 : AW'(p_next_w);
				first_q <= last_s0 ? 1'b0 : first_s0;
			end
			if (s1_valid) begin
				held_q <= center;
			end
			s1_valid <= accept;
			fwd_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1 <= p_s0;
			rb_addr_s1 <= rb_addr_s0;
			energy_s1 <= s_tdata;
			first_s1 <= first_s0;
			last_s1 <= last_s0;
			has_left_s1 <= (p_s0 != '0);
			has_right_s1 <= !last_s0;
		end
		fwd_addr_q <= p_s1;
		fwd_data_q <= cost;
	end

	// Line store: the center and right entries are read as the item is accepted,
	// and the new cost is written back over the center entry in the compute stage.
	sce_ram #(
		.WIDTH(COST_W),
		.DEPTH(MAX_LINE)
	) u_line_store (
		.clk    (clk),
		.we     (s1_valid),
		.waddr  (p_s1),
		.wdata  (cost),
		.raddr_a(p_s0),
		.rdata_a(rd_center),
		.raddr_b(rb_addr_s0),
		.rdata_b(rd_right)
	);

	// The write of the item just before lands on the same edge as this item's
	// read, so the store returns stale data for that entry; take it from the
	// forwarding register instead. This only matters for lines of one or two.
	always_comb begin
		center = (fwd_valid_q && (fwd_addr_q == p_s1)) ? fwd_data_q : rd_center;
		right = (fwd_valid_q && (fwd_addr_q == rb_addr_s1)) ? fwd_data_q : rd_right;
		best = center;
		if (has_left_s1 && (held_q < best)) begin
			best = held_q;
		end
		if (has_right_s1 && (right < best)) begin
			best = right;
		end
		sum = {1'b0, best} + (COST_W + 1)'(energy_s1);
		if (first_s1) begin
			cost = COST_W'(energy_s1);
		end else if (sum[COST_W]) begin
			cost = COST_MAX;
		end else begin
			cost = sum[COST_W-1:0];
		end
	end

	assign push_data.line_end = last_s1;
	assign push_data.path_cost = cost;

	sce_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s1_valid),
		.push_data(push_data),
		.pop_ready(m_tready),
		.out_valid(m_tvalid),
		.out_data (head),
		.count    (fifo_count)
	);

	assign m_tdata = head.path_cost;
	assign m_tlast = head.line_end;

	// The compute stage never stalls, so the queue must have room on every push.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> (fifo_count < FIFO_CW'(FIFO_DEPTH)))
		else $error("result queue overflow");

	// An item is in the compute stage in the cycle after it was accepted.
	a_stage_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> s1_valid)
		else $error("accepted item did not reach compute stage");

	// After the last item of a line the next line starts at position zero
	// outside first-line mode.
	a_line_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && last_s1) |-> ((position_q == '0) && !first_q))
		else $error("line end did not restart position");

	// The effective length stays within the line store.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eff_len_q != '0) && (eff_len_q <= MAX_LEN))
		else $error("effective line length out of range");

endmodule

// File: design/sce_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// Read-during-write to the same address returns the old contents. No dependencies.
module sce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	output logic [WIDTH-1:0]                      rdata_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                      rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: design/sce_out_fifo.sv
// Small result queue between the compute stage and the output channel.
// Depends on sce_pkg for the result type and queue geometry.
module sce_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  sce_pkg::sce_result_t          push_data,
	input  logic                          pop_ready,
	output logic                          out_valid,
	output sce_pkg::sce_result_t          out_data,
	output logic [sce_pkg::FIFO_CW-1:0]   count
);
	import sce_pkg::*;

	sce_result_t       entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;

	assign out_valid = (count_q != '0);
	assign out_data = entry_q[rd_ptr_q];
	assign count = count_q;
	assign pop = out_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CW'(1);
			end else if (!push && pop) begin
				count_q <= count_q - FIFO_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench for seam_cumulative_energy: streams pixel energies with random idling on
// both sides and checks every path cost and line end against a predictor kept here.
// Depends on sce_pkg and the seam_cumulative_energy RTL only.
module tb;
	import sce_pkg::*;

	localparam int MAX_LINE = 1024;
	localparam int STALL_MAX = 18;
	// Margin waited after the last owed cost has come out.
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ENERGY_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [COST_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LEN_W-1:0] cfg_data = '0;

	// Predictor state: the previous line of costs, which entries hold a real
	// value, the element position, first-line mode, the held left neighbor and
	// the line length register.
	bit [COST_W-1:0] cost_line [MAX_LINE];
	bit cost_written [MAX_LINE];
	int col = 0;
	bit on_first_line = 1'b1;
	bit [COST_W-1:0] left_cost = '0;
	bit [LEN_W-1:0] len_reg = LEN_W'(LEN_RESET);

	// Costs still owed by the block, oldest first.
	sce_result_t expected_costs [$];

	int src_gap_max = 0;
	int sink_stall_max = 0;
	int mismatches = 0;
	int results_seen = 0;
	int saturated_seen = 0;
	int settings_written = 0;

	seam_cumulative_energy #(
		.MAX_LINE(MAX_LINE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Line length as the block uses it: zero means one, anything past the
	// store size is clamped to the store size.
	function automatic int active_length();
		int n;
		n = int'(len_reg);
		if (n < 1)
			n = 1;
		if (n > MAX_LINE)
			n = MAX_LINE;
		return n;
	endfunction

	// True when an item without an image start would make the block combine
	// line store entries that were never written. Only the same and the right
	// neighbor need checking; the left one was the previous item's center.
	function automatic bit reads_unwritten();
		int n;
		int p;
		n = active_length();
		p = (col >= n) ? 0 : col;
		if (on_first_line)
			return 1'b0;
		return !cost_written[p] || (p + 1 < n && !cost_written[p + 1]);
	endfunction

	// Advances the predictor by one pixel and queues the cost it must produce.
	function automatic void predict_path_cost(input logic [ENERGY_W-1:0] energy,
			input bit start);
		int n;
		int p;
		int sum;
		bit [COST_W-1:0] above;
		bit [COST_W-1:0] best;
		sce_result_t cost;
		n = active_length();
		if (start) begin
			col = 0;
			on_first_line = 1'b1;
		end
		// A length shrunk under a line in progress restarts the position only.
		if (col >= n)
			col = 0;
		p = col;
		above = cost_line[p];
		if (on_first_line) begin
			sum = int'(energy);
		end else begin
			best = above;
			if (p > 0 && left_cost < best)
				best = left_cost;
			if (p + 1 < n && cost_line[p + 1] < best)
				best = cost_line[p + 1];
			sum = int'(energy) + int'(best);
			if (sum > int'(COST_MAX))
				sum = int'(COST_MAX);
		end
		left_cost = above;
		cost_line[p] = sum[COST_W-1:0];
		cost_written[p] = 1'b1;
		cost.path_cost = sum[COST_W-1:0];
		cost.line_end = (p + 1 >= n);
		if (cost.line_end) begin
			col = 0;
			on_first_line = 1'b0;
		end else begin
			col = p + 1;
		end
		expected_costs.push_back(cost);
	endfunction

	function automatic logic [ENERGY_W-1:0] rand_energy();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return ENERGY_W'($urandom_range(200, 255));
			default: return ENERGY_W'($urandom);
		endcase
	endfunction

	// Chooses how hard each side idles for the next stretch of items.
	function automatic void pick_idling();
		case ($urandom_range(0, 3))
			0: begin
				src_gap_max = 0;
				sink_stall_max = 0;
			end
			1: begin
				src_gap_max = STALL_MAX;
				sink_stall_max = 0;
			end
			2: begin
				src_gap_max = 0;
				sink_stall_max = STALL_MAX;
			end
			default: begin
				src_gap_max = STALL_MAX;
				sink_stall_max = STALL_MAX;
			end
		endcase
	endfunction

	// Sends one pixel and returns at the edge where it was taken. tvalid is left
	// high so that a back-to-back item needs no second assignment in the same
	// step; it drops only ahead of a gap or when the stream goes idle.
	task automatic send_pixel(input logic [ENERGY_W-1:0] energy, input bit start);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (!start && reads_unwritten())
			start = 1'b1;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= energy;
		s_tuser <= start;
		predict_path_cost(energy, start);
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stops the stream and waits until every owed cost has come out.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_costs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		len_reg = value;
		settings_written++;
	endtask

	// The reset length must already be in force: the first line after reset
	// carries no image start and must end after 1024 items. Then an all-ones
	// length, clamped to the store size, starts a second line that combines
	// the stored costs.
	task automatic test_reset_length();
		src_gap_max = STALL_MAX;
		sink_stall_max = STALL_MAX;
		for (int i = 0; i < MAX_LINE; i++)
			send_pixel(rand_energy(), 1'b0);
		write_length('1);
		pick_idling();
		for (int i = 0; i < 48; i++)
			send_pixel(rand_energy(), 1'b0);
	endtask

	// Hand-picked pixels: single-element lines from a zero length, energy
	// extremes, a length shrunk while a line is in progress, and an image start
	// in the middle of a line.
	task automatic test_directed();
		pick_idling();
		write_length('0);
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		write_length(11'd2);
		send_pixel(8'd10, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd2, 1'b0);
		write_length(11'd4);
		send_pixel(8'd5, 1'b1);
		send_pixel(8'd9, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd7, 1'b0);
		repeat (4) send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd255, 1'b0);
		// Two elements into a line of four, the line shrinks to two.
		write_length(11'd2);
		send_pixel(8'd3, 1'b0);
		send_pixel(8'd4, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd8, 1'b1);
		send_pixel(8'd9, 1'b0);
		send_pixel(8'd0, 1'b0);
	endtask

	// Mostly whole images with random energies under a run of line lengths,
	// each phase ending wherever it ends so the next length may cut a line
	// short. Images restart now and then at a line boundary and rarely mid-line.
	task automatic test_random_lines(input int phases);
		logic [LEN_W-1:0] setting;
		int count;
		bit start;
		for (int ph = 0; ph < phases; ph++) begin
			case (ph)
				0: setting = 11'd3;
				1: setting = 11'd0;
				2: setting = 11'd8;
				3: setting = 11'd1;
				4: setting = 11'd13;
				5: setting = 11'd5;
				6: setting = 11'd1536;
				7: setting = 11'd2;
				default: setting = LEN_W'($urandom_range(1, 40));
			endcase
			write_length(setting);
			pick_idling();
			count = $urandom_range(20, 50);
			start = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < count; i++) begin
				send_pixel(rand_energy(), start);
				start = (col == 0 && $urandom_range(0, 11) == 0) ||
					$urandom_range(0, 59) == 0;
			end
		end
	endtask

	// One-element lines of maximum energy reach 65535 on line 257 and would
	// pass it from then on.
	task automatic test_saturation();
		write_length(11'd1);
		pick_idling();
		send_pixel(8'd255, 1'b1);
		repeat (259) send_pixel(8'd255, 1'b0);
	endtask

	// Result side: random stalls per item, and every accepted result is held
	// against the oldest owed cost. Outputs are read before this edge's updates.
	initial begin
		sce_result_t owed;
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				results_seen++;
				if (m_tdata == COST_MAX)
					saturated_seen++;
				if (expected_costs.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got cost %0d line end %0b",
						$time, m_tdata, m_tlast);
				end else begin
					owed = expected_costs.pop_front();
					if (m_tdata !== owed.path_cost) begin
						mismatches++;
						$display("%0t: path_cost expected %0d, got %0d",
							$time, owed.path_cost, m_tdata);
					end
					if (m_tlast !== owed.line_end) begin
						mismatches++;
						$display("%0t: line_end expected %0b, got %0b",
							$time, owed.line_end, m_tlast);
					end
				end
				stall = $urandom_range(0, sink_stall_max);
			end else if (stall > 0) begin
				stall--;
			end
			m_tready <= (stall == 0);
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_length();
		test_directed();
		test_random_lines(8);
		test_saturation();
		wait_idle();
		$display("Checked %0d path costs under %0d line length writes,", results_seen,
			settings_written);
		$display("with %0d of them pinned at the saturation ceiling.", saturated_seen);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#16_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
design/sce_pkg.sv
design/sce_ram.sv
design/sce_out_fifo.sv
design/seam_cumulative_energy.sv
test/tb.sv
